FILE: rtl/hrhp_pkg.sv
// Package for the HTTP request header parser: phase codes, field kinds,
// status codes and byte class helpers. No dependencies.
package hrhp_pkg;

  localparam int LengthBits = 32;

  typedef enum logic [4:0] {
    PH_METHOD_START = 5'd0, PH_METHOD = 5'd1, PH_URI_START = 5'd2, PH_URI = 5'd3,
    PH_VER_H = 5'd4, PH_VER_T1 = 5'd5, PH_VER_T2 = 5'd6, PH_VER_P = 5'd7,
    PH_VER_SLASH = 5'd8, PH_MAJOR_START = 5'd9, PH_MAJOR = 5'd10,
    PH_MINOR_START = 5'd11, PH_MINOR = 5'd12, PH_NL_LINE = 5'd13,
    PH_HDR_LINE_START = 5'd14, PH_HDR_LWS = 5'd15, PH_HDR_NAME = 5'd16,
    PH_SPACE_VALUE = 5'd17, PH_HDR_VALUE = 5'd18, PH_NL_HDR = 5'd19,
    PH_NL_END = 5'd20, PH_BODY = 5'd21
  } phase_t;

  localparam logic [2:0] KIND_FRAME  = 3'd0;
  localparam logic [2:0] KIND_METHOD = 3'd1;
  localparam logic [2:0] KIND_URI    = 3'd2;
  localparam logic [2:0] KIND_NAME   = 3'd3;
  localparam logic [2:0] KIND_VALUE  = 3'd4;
  localparam logic [2:0] KIND_BODY   = 3'd5;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic OP_PARSE   = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  field_kind;
    logic [7:0]  echo_byte;
    logic        header_start;
    logic [7:0]  version_major;
    logic [7:0]  version_minor;
    logic [31:0] body_length;
  } result_t;

  function automatic logic is_ctl(input logic [7:0] b);
    return (b <= 8'd31) || (b == 8'd127);
  endfunction

  function automatic logic is_tok(input logic [7:0] b);
    logic r;
    r = !((b <= 8'd31) || (b >= 8'd127));
    case (b)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?",
      "=", "{", "}", " ": r = 1'b0;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic is_dig(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic [7:0] post_char(input logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0: c = "P";
      2'd1: c = "O";
      2'd2: c = "S";
      default: c = "T";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] cl_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0: c = "C";  4'd1: c = "o";  4'd2: c = "n";  4'd3: c = "t";
      4'd4: c = "e";  4'd5: c = "n";  4'd6: c = "t";  4'd7: c = "-";
      4'd8: c = "L";  4'd9: c = "e";  4'd10: c = "n"; 4'd11: c = "g";
      4'd12: c = "t"; default: c = "h";
    endcase
    return c;
  endfunction

  // v*10 + digit, saturating at 255
  function automatic logic [7:0] ver_acc(input logic [7:0] v, input logic [7:0] b);
    logic [11:0] n;
    n = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {8'd0, b[3:0]};
    return (n > 12'd255) ? 8'd255 : n[7:0];
  endfunction

endpackage

FILE: rtl/hrhp_core.sv
// Parser state and next-state logic for one byte per cycle; state advances only on step.
// Depends on hrhp_pkg.
module hrhp_core import hrhp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        opcode,
  input  logic [7:0]  data_byte,
  input  logic [31:0] max_body_length,
  output result_t     res
);

  phase_t          parse_phase, parse_phase_next;
  logic [7:0]      major_number, major_number_next, minor_number, minor_number_next;
  logic [2:0]      post_match_index, post_match_index_next;
  logic            post_mismatch, post_mismatch_next;
  logic [3:0]      name_match_index, name_match_index_next;
  logic            name_mismatch, name_mismatch_next;
  logic            any_header_seen, any_header_seen_next;
  logic            in_length_value, in_length_value_next;
  logic            length_found, length_found_next;
  logic [LengthBits:0] length_value, length_value_next;
  logic            length_digits_ok, length_digits_ok_next;
  logic [31:0]     body_remaining, body_remaining_next;
  logic [1:0]      finished, finished_next;
  logic [2:0]      kind;
  logic            hs, err;
  logic [LengthBits+4:0] lv_mul;
  logic            is_post_next;

  localparam logic [LengthBits:0] Cap = {1'b1, {LengthBits{1'b0}}};

  always_comb begin
    lv_mul = {1'b0, length_value, 3'b000} + {3'b000, length_value, 1'b0}
           + {{(LengthBits+1){1'b0}}, data_byte[3:0]};
  end

  always_comb begin
    parse_phase_next = parse_phase;
    major_number_next = major_number;
    minor_number_next = minor_number;
    post_match_index_next = post_match_index;
    post_mismatch_next = post_mismatch;
    name_match_index_next = name_match_index;
    name_mismatch_next = name_mismatch;
    any_header_seen_next = any_header_seen;
    in_length_value_next = in_length_value;
    length_found_next = length_found;
    length_value_next = length_value;
    length_digits_ok_next = length_digits_ok;
    body_remaining_next = body_remaining;
    finished_next = finished;
    kind = KIND_FRAME;
    hs = 1'b0;
    err = 1'b0;
    if (opcode == OP_RESTART) begin
      parse_phase_next = PH_METHOD_START;
      major_number_next = '0; minor_number_next = '0;
      post_match_index_next = '0; post_mismatch_next = 1'b0;
      name_match_index_next = '0; name_mismatch_next = 1'b0;
      any_header_seen_next = 1'b0; in_length_value_next = 1'b0;
      length_found_next = 1'b0; length_value_next = '0; length_digits_ok_next = 1'b0;
      body_remaining_next = '0; finished_next = ST_RUN;
    end else if (finished == ST_RUN) begin
      unique case (parse_phase)
        PH_METHOD_START, PH_METHOD: begin
          if (parse_phase == PH_METHOD && data_byte == " ") begin
            parse_phase_next = PH_URI_START;
          end else if (!is_tok(data_byte)) begin
            err = 1'b1;
          end else begin
            if (!post_mismatch && post_match_index < 3'd4 &&
                data_byte == post_char(post_match_index[1:0]))
              post_match_index_next = post_match_index + 3'd1;
            else
              post_mismatch_next = 1'b1;
            parse_phase_next = PH_METHOD;
            kind = KIND_METHOD;
          end
        end
        PH_URI_START, PH_URI: begin
          if (parse_phase == PH_URI && data_byte == " ") parse_phase_next = PH_VER_H;
          else if (is_ctl(data_byte)) err = 1'b1;
          else begin
            parse_phase_next = PH_URI;
            kind = KIND_URI;
          end
        end
        PH_VER_H:  if (data_byte == "H") parse_phase_next = PH_VER_T1; else err = 1'b1;
        PH_VER_T1: if (data_byte == "T") parse_phase_next = PH_VER_T2; else err = 1'b1;
        PH_VER_T2: if (data_byte == "T") parse_phase_next = PH_VER_P; else err = 1'b1;
        PH_VER_P:  if (data_byte == "P") parse_phase_next = PH_VER_SLASH; else err = 1'b1;
        PH_VER_SLASH: begin
          if (data_byte == "/") begin
            major_number_next = '0; minor_number_next = '0;
            parse_phase_next = PH_MAJOR_START;
          end else err = 1'b1;
        end
        PH_MAJOR_START: begin
          if (is_dig(data_byte)) begin
            major_number_next = ver_acc(major_number, data_byte);
            parse_phase_next = PH_MAJOR;
          end else err = 1'b1;
        end
        PH_MAJOR: begin
          if (data_byte == ".") parse_phase_next = PH_MINOR_START;
          else if (is_dig(data_byte)) major_number_next = ver_acc(major_number, data_byte);
          else err = 1'b1;
        end
        PH_MINOR_START: begin
          if (is_dig(data_byte)) begin
            minor_number_next = ver_acc(minor_number, data_byte);
            parse_phase_next = PH_MINOR;
          end else err = 1'b1;
        end
        PH_MINOR: begin
          if (data_byte == 8'h0d) parse_phase_next = PH_NL_LINE;
          else if (is_dig(data_byte)) minor_number_next = ver_acc(minor_number, data_byte);
          else err = 1'b1;
        end
        PH_NL_LINE, PH_NL_HDR: begin
          if (data_byte == 8'h0a) parse_phase_next = PH_HDR_LINE_START; else err = 1'b1;
        end
        PH_HDR_LINE_START: begin
          if (data_byte == 8'h0d) parse_phase_next = PH_NL_END;
          else if (any_header_seen && (data_byte == " " || data_byte == 8'h09))
            parse_phase_next = PH_HDR_LWS;
          else if (!is_tok(data_byte)) err = 1'b1;
          else begin
            any_header_seen_next = 1'b1;
            in_length_value_next = 1'b0;
            name_mismatch_next = (data_byte != cl_char(4'd0));
            name_match_index_next = (data_byte != cl_char(4'd0)) ? 4'd0 : 4'd1;
            parse_phase_next = PH_HDR_NAME;
            kind = KIND_NAME;
            hs = 1'b1;
          end
        end
        PH_HDR_NAME: begin
          if (data_byte == ":") begin
            if (!length_found && !name_mismatch && name_match_index == 4'd14) begin
              length_found_next = 1'b1; in_length_value_next = 1'b1;
              length_value_next = '0; length_digits_ok_next = 1'b0;
            end
            parse_phase_next = PH_SPACE_VALUE;
          end else if (!is_tok(data_byte)) err = 1'b1;
          else begin
            if (!name_mismatch && name_match_index < 4'd14 &&
                data_byte == cl_char(name_match_index))
              name_match_index_next = name_match_index + 4'd1;
            else
              name_mismatch_next = 1'b1;
            kind = KIND_NAME;
          end
        end
        PH_SPACE_VALUE: if (data_byte == " ") parse_phase_next = PH_HDR_VALUE; else err = 1'b1;
        PH_HDR_LWS, PH_HDR_VALUE: begin
          if (data_byte == 8'h0d) parse_phase_next = PH_NL_HDR;
          else if (parse_phase == PH_HDR_LWS && (data_byte == " " || data_byte == 8'h09)) begin
          end else if (is_ctl(data_byte)) err = 1'b1;
          else begin
            parse_phase_next = PH_HDR_VALUE;
            kind = KIND_VALUE;
            if (in_length_value) begin
              if (!is_dig(data_byte)) begin
                in_length_value_next = 1'b0;
                length_digits_ok_next = 1'b0;
              end else begin
                // saturate at 2^LengthBits once the product passes it
                length_value_next = (lv_mul > {4'd0, Cap}) ? Cap : lv_mul[LengthBits:0];
                length_digits_ok_next = 1'b1;
              end
            end
          end
        end
        PH_NL_END: begin
          if (data_byte != 8'h0a) err = 1'b1;
          else if (!(!post_mismatch && post_match_index == 3'd4)) finished_next = ST_DONE;
          else if (!length_found || !length_digits_ok ||
                   length_value > {1'b0, max_body_length}) err = 1'b1;
          else begin
            body_remaining_next = length_value[31:0];
            if (length_value[31:0] == '0) finished_next = ST_DONE;
            else parse_phase_next = PH_BODY;
          end
        end
        PH_BODY: begin
          kind = KIND_BODY;
          body_remaining_next = body_remaining - 32'd1;
          if (body_remaining == 32'd1) finished_next = ST_DONE;
        end
        default: err = 1'b1;
      endcase
      if (err) begin
        finished_next = ST_ERR;
        kind = KIND_FRAME;
        hs = 1'b0;
      end
    end
  end

  assign is_post_next = !post_mismatch_next && post_match_index_next == 3'd4;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= PH_METHOD_START;
      major_number <= '0; minor_number <= '0;
      post_match_index <= '0; post_mismatch <= 1'b0;
      name_match_index <= '0; name_mismatch <= 1'b0;
      any_header_seen <= 1'b0; in_length_value <= 1'b0;
      length_found <= 1'b0; length_value <= '0; length_digits_ok <= 1'b0;
      body_remaining <= '0; finished <= ST_RUN;
    end else if (step) begin
      parse_phase <= parse_phase_next;
      major_number <= major_number_next; minor_number <= minor_number_next;
      post_match_index <= post_match_index_next; post_mismatch <= post_mismatch_next;
      name_match_index <= name_match_index_next; name_mismatch <= name_mismatch_next;
      any_header_seen <= any_header_seen_next; in_length_value <= in_length_value_next;
      length_found <= length_found_next; length_value <= length_value_next;
      length_digits_ok <= length_digits_ok_next;
      body_remaining <= body_remaining_next; finished <= finished_next;
    end
  end

  always_comb begin
    res.status = finished_next;
    res.field_kind = kind;
    res.echo_byte = data_byte;
    res.header_start = hs;
    res.version_major = major_number_next;
    res.version_minor = minor_number_next;
    res.body_length = (is_post_next && finished_next != ST_ERR &&
                       (parse_phase_next == PH_BODY || finished_next == ST_DONE))
                      ? length_value_next[31:0] : 32'd0;
  end

endmodule

FILE: rtl/hrhp_out_reg.sv
// Output register with skid stage for result items.
// Depends on hrhp_pkg.
module hrhp_out_reg import hrhp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t skid;
  logic    skid_valid;
  logic    out_valid_next, skid_valid_next;

  assign in_ready = !skid_valid;

  always_comb begin
    out_valid_next = out_valid;
    skid_valid_next = skid_valid;
    if (out_valid && out_ready) begin
      out_valid_next = skid_valid;
      skid_valid_next = 1'b0;
    end
    if (in_valid && in_ready) begin
      if (out_valid && !out_ready) skid_valid_next = 1'b1;
      else out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready && skid_valid) out_data <= skid;
    if (in_valid && in_ready) begin
      if (out_valid && !out_ready) skid <= in_data;
      else out_data <= in_data;
    end
  end

endmodule

FILE: rtl/http_request_header_parser.sv
// HTTP request header parser: one input item per cycle, one result item each.
// Each result is registered in the output register, or in the skid slot while the output stalls.
// Throughput: one item per clock while results drain; a stalled result lets one
// more item into the skid slot, and input resumes the cycle after it empties.
// Reset (rst, synchronous): parser to method start, max_body_length to 65535.
// Depends on hrhp_pkg, hrhp_core, hrhp_out_reg.
module http_request_header_parser import hrhp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [4:2] field_kind, [12:5] echo_byte, [13] header_start,
  // [21:14] version_major, [29:22] version_minor, [61:30] body_length, rest 0
  output logic [63:0] m_axis_tdata
);

  logic [31:0] max_body_length;
  result_t     res, res_q;
  logic        step;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) max_body_length <= 32'd65535;
    else if (cfg_we) max_body_length <= cfg_wdata;
  end

  assign step = s_axis_tvalid && s_axis_tready;

  hrhp_core u_core (
    .clk, .rst, .step,
    .opcode(s_axis_tuser), .data_byte(s_axis_tdata),
    .max_body_length, .res
  );

  hrhp_out_reg u_out (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(res),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res_q)
  );

  assign m_axis_tdata = {2'b00, res_q.body_length, res_q.version_minor,
                         res_q.version_major, res_q.header_start, res_q.echo_byte,
                         res_q.field_kind, res_q.status};

  // status codes never exceed malformed
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3)) else $error("bad status");
  // body length is reported only with a non-error status
  a_len: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[1:0] == ST_ERR) |-> (m_axis_tdata[61:30] == 32'd0))
    else $error("length on error");
  // header start only on header name bytes
  a_hs: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[13]) |-> (m_axis_tdata[4:2] == KIND_NAME))
    else $error("header start off name");

endmodule

FILE: tb/sv/tb_top.sv
// Testbench for the HTTP request header parser: drives byte items and
// restarts, predicts every result item and checks it field by field.
// Depends on hrhp_pkg and the http_request_header_parser RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hrhp_pkg::*;

  // Parser shadow state, kept in the block's own terms
  typedef struct {
    phase_t      ph;
    logic [7:0]  major, minor;
    logic [2:0]  post_idx;
    logic        post_bad;
    logic [3:0]  name_idx;
    logic        name_bad;
    logic        any_hdr;
    logic        in_len;
    logic        len_found;
    logic [32:0] len_val;
    logic        len_ok;
    logic [31:0] body_left;
    logic [1:0]  done;
  } parse_state_t;

  class http_scoreboard;
    parse_state_t st;
    logic [31:0]  max_len;
    result_t      pending[$];
    int           errors;

    function void clear();
      st = '{ph: PH_METHOD_START, default: '0};
    endfunction

    function void do_reset();
      clear();
      max_len = 32'd65535;
      pending.delete();
      errors = 0;
    endfunction

    function bit tok(logic [7:0] b);
      if (b <= 8'd31 || b >= 8'd127) return 0;
      case (b)
        "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?",
        "=", "{", "}", " ": return 0;
        default: return 1;
      endcase
    endfunction

    function bit ctl(logic [7:0] b);
      return b <= 8'd31 || b == 8'd127;
    endfunction

    function bit dig(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function logic [7:0] acc(logic [7:0] v, logic [7:0] b);
      int n;
      n = v * 10 + (b - "0");
      return (n > 255) ? 8'd255 : n[7:0];
    endfunction

    function bit post_req();
      return !st.post_bad && st.post_idx == 3'd4;
    endfunction

    function void length_digit(logic [7:0] b);
      logic [33:0] cap;
      logic [33:0] d;
      cap = 34'd1 << 32;
      if (!st.in_len) return;
      if (!dig(b)) begin
        st.in_len = 0;
        st.len_ok = 0;
        return;
      end
      d = b - "0";
      if ({1'b0, st.len_val} > (cap - d) / 10) st.len_val = cap[32:0];
      else st.len_val = st.len_val * 10 + d;
      st.len_ok = 1;
    endfunction

    // Note one accepted input item and queue its expected result
    function void note_input(logic op, logic [7:0] b);
      string post_w, cl_w;
      logic [2:0] kind;
      bit hs, err;
      result_t r;
      post_w = "POST";
      cl_w = "Content-Length";
      kind = KIND_FRAME;
      hs = 0;
      err = 0;
      if (op == OP_RESTART) clear();
      else if (st.done == ST_RUN) begin
        case (st.ph)
          PH_METHOD_START, PH_METHOD: begin
            if (st.ph == PH_METHOD && b == " ") st.ph = PH_URI_START;
            else if (!tok(b)) err = 1;
            else begin
              if (!st.post_bad && st.post_idx < 4 && b == post_w[st.post_idx])
                st.post_idx++;
              else st.post_bad = 1;
              st.ph = PH_METHOD;
              kind = KIND_METHOD;
            end
          end
          PH_URI_START, PH_URI: begin
            if (st.ph == PH_URI && b == " ") st.ph = PH_VER_H;
            else if (ctl(b)) err = 1;
            else begin
              st.ph = PH_URI;
              kind = KIND_URI;
            end
          end
          PH_VER_H: if (b == "H") st.ph = PH_VER_T1; else err = 1;
          PH_VER_T1: if (b == "T") st.ph = PH_VER_T2; else err = 1;
          PH_VER_T2: if (b == "T") st.ph = PH_VER_P; else err = 1;
          PH_VER_P: if (b == "P") st.ph = PH_VER_SLASH; else err = 1;
          PH_VER_SLASH: begin
            if (b == "/") begin
              st.major = 0;
              st.minor = 0;
              st.ph = PH_MAJOR_START;
            end else err = 1;
          end
          PH_MAJOR_START: begin
            if (dig(b)) begin
              st.major = acc(st.major, b);
              st.ph = PH_MAJOR;
            end else err = 1;
          end
          PH_MAJOR: begin
            if (b == ".") st.ph = PH_MINOR_START;
            else if (dig(b)) st.major = acc(st.major, b);
            else err = 1;
          end
          PH_MINOR_START: begin
            if (dig(b)) begin
              st.minor = acc(st.minor, b);
              st.ph = PH_MINOR;
            end else err = 1;
          end
          PH_MINOR: begin
            if (b == 8'h0d) st.ph = PH_NL_LINE;
            else if (dig(b)) st.minor = acc(st.minor, b);
            else err = 1;
          end
          PH_NL_LINE, PH_NL_HDR: if (b == 8'h0a) st.ph = PH_HDR_LINE_START; else err = 1;
          PH_HDR_LINE_START: begin
            if (b == 8'h0d) st.ph = PH_NL_END;
            else if (st.any_hdr && (b == " " || b == 8'h09)) st.ph = PH_HDR_LWS;
            else if (!tok(b)) err = 1;
            else begin
              st.any_hdr = 1;
              st.in_len = 0;
              st.name_bad = (b != "C");
              st.name_idx = st.name_bad ? 4'd0 : 4'd1;
              st.ph = PH_HDR_NAME;
              kind = KIND_NAME;
              hs = 1;
            end
          end
          PH_HDR_LWS: begin
            if (b == 8'h0d) st.ph = PH_NL_HDR;
            else if (b == " " || b == 8'h09) ;
            else if (ctl(b)) err = 1;
            else begin
              length_digit(b);
              st.ph = PH_HDR_VALUE;
              kind = KIND_VALUE;
            end
          end
          PH_HDR_NAME: begin
            if (b == ":") begin
              if (!st.len_found && !st.name_bad && st.name_idx == 4'd14) begin
                st.len_found = 1;
                st.in_len = 1;
                st.len_val = 0;
                st.len_ok = 0;
              end
              st.ph = PH_SPACE_VALUE;
            end else if (!tok(b)) err = 1;
            else begin
              if (!st.name_bad && st.name_idx < 14 && b == cl_w[st.name_idx])
                st.name_idx++;
              else st.name_bad = 1;
              kind = KIND_NAME;
            end
          end
          PH_SPACE_VALUE: if (b == " ") st.ph = PH_HDR_VALUE; else err = 1;
          PH_HDR_VALUE: begin
            if (b == 8'h0d) st.ph = PH_NL_HDR;
            else if (ctl(b)) err = 1;
            else begin
              length_digit(b);
              kind = KIND_VALUE;
            end
          end
          PH_NL_END: begin
            if (b != 8'h0a) err = 1;
            else if (!post_req()) st.done = ST_DONE;
            else if (!st.len_found || !st.len_ok || st.len_val > {1'b0, max_len}) err = 1;
            else begin
              st.body_left = st.len_val[31:0];
              if (st.body_left == 0) st.done = ST_DONE;
              else st.ph = PH_BODY;
            end
          end
          PH_BODY: begin
            kind = KIND_BODY;
            st.body_left = st.body_left - 1;
            if (st.body_left == 0) st.done = ST_DONE;
          end
          default: err = 1;
        endcase
        if (err) begin
          st.done = ST_ERR;
          kind = KIND_FRAME;
          hs = 0;
        end
      end
      r.status = st.done;
      r.field_kind = kind;
      r.echo_byte = b;
      r.header_start = hs;
      r.version_major = st.major;
      r.version_minor = st.minor;
      r.body_length = (post_req() && st.done != ST_ERR &&
                       (st.ph == PH_BODY || st.done == ST_DONE)) ? st.len_val[31:0] : 32'd0;
      pending = {pending, r};
    endfunction

    function void flag(string what, logic [63:0] got, logic [63:0] want);
      $display("ERROR %s: got %0h expected %0h", what, got, want);
      errors++;
    endfunction

    // Compare one accepted result item with the oldest expectation
    function void check_result(logic [63:0] d);
      result_t e;
      if (pending.size() == 0) begin
        flag("unexpected result", d, 0);
        return;
      end
      e = pending.pop_front();
      if (d[1:0] !== e.status) flag("status", d[1:0], e.status);
      if (d[4:2] !== e.field_kind) flag("field_kind", d[4:2], e.field_kind);
      if (d[12:5] !== e.echo_byte) flag("echo_byte", d[12:5], e.echo_byte);
      if (d[13] !== e.header_start) flag("header_start", d[13], e.header_start);
      if (d[21:14] !== e.version_major) flag("version_major", d[21:14], e.version_major);
      if (d[29:22] !== e.version_minor) flag("version_minor", d[29:22], e.version_minor);
      if (d[61:30] !== e.body_length) flag("body_length", d[61:30], e.body_length);
      if (d[63:62] !== 2'b00) flag("pad bits", d[63:62], 0);
    endfunction
  endclass

  logic        clk, rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        s_axis_tvalid, s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid, m_axis_tready;
  logic [63:0] m_axis_tdata;

  http_scoreboard sb;
  int  cycles;
  bit  calm;          // while set, neither side idles
  int  bytes_sent, restarts_sent, configs_done;
  byte q_bytes[$];    // one request worth of bytes, built before sending

  http_request_header_parser dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 200000) begin
        $display("timeout after %0d cycles", cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Sample results at the rising edge; change ready at the falling edge
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 33);
  end

  // Send one item; hold it until accepted, leave valid up for the next one
  task automatic send_item(input logic op, input logic [7:0] b);
    while (!calm && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(op, b);
    if (op == OP_RESTART) restarts_sent++; else bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_restart();
    send_item(OP_RESTART, $urandom_range(255));
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_item(OP_PARSE, s[i]);
  endtask

  // Drop valid, wait for all results, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_max(input logic [31:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.max_len = v;
    configs_done++;
  endtask

  function automatic void push_str(input string s);
    foreach (s[i]) q_bytes = {q_bytes, s[i]};
  endfunction

  function automatic void push_byte(input byte v);
    q_bytes = {q_bytes, v};
  endfunction

  function automatic string rand_token(input int n);
    string t;
    string alpha;
    int    k;
    alpha = "abcXYZ09-_.!~*+POSTGE";
    t = "";
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(alpha.len() - 1);
      t = {t, alpha.substr(k, k)};
    end
    return t;
  endfunction

  // Build a mostly well-formed request with random content and some damage
  function automatic void build_request();
    int    body;
    bit    post;
    string ver;
    q_bytes.delete();
    post = $urandom_range(99) < 60;
    if (post) push_str("POST");
    else if ($urandom_range(1)) push_str("GET");
    else push_str(rand_token($urandom_range(1, 5)));
    push_str(" /");
    for (int i = $urandom_range(3); i > 0; i--)
      push_byte($urandom_range(1) ? $urandom_range(128, 255) : $urandom_range(33, 126));
    push_str(" HTTP/");
    ver = $sformatf("%0d.%0d", $urandom_range(1) ? 1 : $urandom_range(999),
                    $urandom_range(1) ? $urandom_range(9) : $urandom_range(9999));
    push_str({ver, "\r\n"});
    body = $urandom_range(9);
    for (int h = $urandom_range(3); h >= 0; h--) begin
      case ($urandom_range(5))
        0, 1: push_str($sformatf("Content-Length: %0d\r\n", body));
        2: begin
          push_str("Content-Length: ");
          if ($urandom_range(1)) push_str("1\r\n 2");
          else push_str("9x");
          push_str("\r\n");
        end
        3: begin
          push_str({rand_token($urandom_range(1, 6)), ": v"});
          push_byte($urandom_range(128, 255));
          push_str("\r\n\tfold\r\n");
        end
        default: push_str({"Content-length: 7", "\r\n"});
      endcase
    end
    push_str("\r\n");
    for (int i = 0; i < body + $urandom_range(2); i++) push_byte($urandom_range(255));
    // Damage roughly one request in six
    if ($urandom_range(5) == 0) q_bytes[$urandom_range(q_bytes.size() - 1)] = $urandom_range(255);
  endfunction

  initial begin
    sb = new();
    sb.do_reset();
    calm = 0;
    bytes_sent = 0;
    restarts_sent = 0;
    configs_done = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_PARSE;
    m_axis_tready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: POST with a two-byte body under the reset maximum, then bad bytes and extremes
    send_text("POST / HTTP/1.1\r\nContent-Length: 2\r\n\r\n");
    send_item(OP_PARSE, 8'hff);
    send_item(OP_PARSE, 8'h00);
    send_item(OP_PARSE, 8'h41);   // ignored after completion
    send_restart();
    send_text(" ");               // space before any method byte is malformed
    send_item(OP_PARSE, 8'h80);   // ignored after error
    send_restart();
    send_text("G  ");             // second space, at URI start, is taken as a URI byte
    send_restart();
    send_text("GET \x80 HTTP/999.999\r\n\r");   // saturating versions
    send_item(OP_PARSE, 8'h00);                  // final CR without LF

    // Register extremes: zero and all ones
    write_max(32'd0);
    send_restart();
    send_text("POST x HTTP/1.0\r\nContent-Length: 1\r\n\r\n");
    send_restart();
    send_text("POST x HTTP/1.0\r\nContent-Length: 0\r\n\r\n");
    write_max(32'hffff_ffff);
    send_restart();
    send_text("POST x HTTP/1.0\r\nContent-Length: 4294967296\r\n\r\n");
    send_restart();
    send_text("POST x HTTP/1.0\r\nContent-Length: 4294967295\r\n\r\nab");
    send_restart();
    send_text("POST x HTTP/1.0\r\nX: y\r\n \t\r\nContent-Length:  3\r\n\r\n");
    write_max(32'd5);

    // Random requests; the second one runs with no idling at all
    for (int n = 0; n < 3; n++) begin
      if (n == 1) calm = 1;
      if (n == 2) begin
        calm = 0;
        drain();   // sender holds until all results are back
        write_max(32'd8);
      end
      build_request();
      send_restart();
      foreach (q_bytes[i]) send_item(OP_PARSE, q_bytes[i]);
      // Sprinkle pure noise items now and then
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(1, 4)) send_item($urandom_range(1), $urandom_range(255));
    end

    drain();
    repeat (10) @(negedge clk);
    if (sb.pending.size() != 0) begin
      $display("ERROR %0d expected results never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("Covered %0d parse bytes, %0d restarts, %0d limit writes in %0d cycles",
             bytes_sent, restarts_sent, configs_done, cycles);
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
